// ===== hw/rtl/double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue assertion macros
// Shared property shapes for the deque checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Types and codes shared by the deque controller, datapath and top level.
// ----------------------------------------------------------------------------
package dq_pkg;

    // width of the item and result words on the ports
    localparam int ITEM_WIDTH = 32;

    // operation codes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_REAR  = 3'd1;
    localparam logic [2:0] OP_REM_FRONT = 3'd2;
    localparam logic [2:0] OP_REM_REAR  = 3'd3;
    localparam logic [2:0] OP_LIST      = 3'd4;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_dq_status;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } t_dq_state;

    // input transaction payload
    typedef struct packed {
        logic [2:0]                   op;
        logic signed [ITEM_WIDTH-1:0] item_value;
    } t_dq_in_item;

    // output transaction payload
    typedef struct packed {
        logic signed [ITEM_WIDTH-1:0] data_value;
        logic [1:0]                   status;
        logic                         last_of_run;
    } t_dq_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic       push_front;
        logic       push_rear;
        logic       pop_front;
        logic       pop_rear;
        logic       walk_start;
        logic       walk_next;
        logic       put_code;
        logic       put_word;
        t_dq_status code;
    } t_dq_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic word_last;
    } t_dq_stat;

endpackage

// ===== hw/rtl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Deque controller: decodes each accepted operation and sequences result
// emission for removals and listings.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_op,
    input  dq_pkg::t_dq_stat i_stat,
    output logic             o_in_ready,
    output dq_pkg::t_dq_cmd  o_cmd
);

    import dq_pkg::*;

    t_dq_state r_state;
    t_dq_state n_state;
    logic      w_accept;

    // an item is taken only while idle with the output slot free
    assign w_accept = (r_state == S_IDLE) && i_stat.out_free && i_in_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_REM_FRONT, OP_REM_REAR, OP_LIST: begin
                            if (!i_stat.empty) begin
                                n_state = S_EMIT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EMIT: begin
                if (i_stat.out_free && i_stat.word_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.code = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (w_accept) begin
                    case (i_op)
                        OP_INS_FRONT, OP_INS_REAR: begin
                            o_cmd.put_code = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.code = ST_FULL;
                            end else begin
                                o_cmd.push_front = (i_op == OP_INS_FRONT);
                                o_cmd.push_rear  = (i_op == OP_INS_REAR);
                            end
                        end
                        OP_REM_FRONT, OP_REM_REAR: begin
                            if (i_stat.empty) begin
                                o_cmd.put_code = 1'b1;
                                o_cmd.code     = ST_EMPTY;
                            end else begin
                                o_cmd.pop_front = (i_op == OP_REM_FRONT);
                                o_cmd.pop_rear  = (i_op == OP_REM_REAR);
                            end
                        end
                        OP_LIST: begin
                            if (i_stat.empty) begin
                                o_cmd.put_code = 1'b1;
                                o_cmd.code     = ST_EMPTY;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                            end
                        end
                        default: begin
                            // unknown codes are dropped without a result
                            o_cmd.put_code = 1'b0;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.put_word  = 1'b1;
                    o_cmd.walk_next = !i_stat.word_last;
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/dq_dp.sv =====
// ----------------------------------------------------------------------------
// dq_dp
// Deque datapath: ring RAM, front pointer, entry count, listing walk index
// and the output register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module dq_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dq_pkg::t_dq_cmd                   i_cmd,
    input  logic signed [dq_pkg::ITEM_WIDTH-1:0] i_item_value,
    input  logic                              i_out_ready,
    output dq_pkg::t_dq_stat                  o_stat,
    output logic                              o_out_valid,
    output dq_pkg::t_dq_out_item              o_out_data
);

    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int EW = (DATA_WIDTH > ITEM_WIDTH) ? DATA_WIDTH : ITEM_WIDTH;

    logic [AW-1:0]         r_front;
    logic [AW-1:0]         n_front;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_walk;
    logic [CW-1:0]         n_walk;
    logic                  r_word_last;
    logic                  n_word_last;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_dq_out_item          r_out_data;
    t_dq_out_item          n_out_data;

    logic [AW-1:0]         w_front_dec;
    logic [AW-1:0]         w_front_inc;
    logic [AW-1:0]         w_rear_wr;
    logic [AW-1:0]         w_rear_rd;
    logic [AW-1:0]         w_walk_addr;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [EW-1:0]         w_item_ext;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [EW-1:0]         w_rd_ext;
    logic                  w_out_free;

    // fold a sum below twice the depth back into the ring
    function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return t[AW-1:0];
    endfunction

    // ring addresses
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign w_front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign w_rear_wr   = wrap_sum(SW'(r_front) + SW'(r_count));
    assign w_rear_rd   = wrap_sum(SW'(r_front) + SW'(r_count) - SW'(1));
    assign w_walk_addr = wrap_sum(SW'(r_front) + SW'(n_walk));

    // walk index for listings
    always_comb begin
        n_walk = r_walk;
        if (i_cmd.walk_start) begin
            n_walk = '0;
        end else if (i_cmd.walk_next) begin
            n_walk = r_walk + 1'b1;
        end
    end

    // last-result flag for the word being read
    always_comb begin
        n_word_last = r_word_last;
        if (i_cmd.pop_front || i_cmd.pop_rear) begin
            n_word_last = 1'b1;
        end else if (i_cmd.walk_start || i_cmd.walk_next) begin
            n_word_last = ((n_walk + 1'b1) == r_count);
        end
    end

    // ram port control
    assign w_item_ext = EW'($unsigned(i_item_value));
    assign w_we       = i_cmd.push_front || i_cmd.push_rear;
    assign w_waddr    = i_cmd.push_front ? w_front_dec : w_rear_wr;
    assign w_re       = i_cmd.pop_front || i_cmd.pop_rear
                        || i_cmd.walk_start || i_cmd.walk_next;
    assign w_raddr    = i_cmd.pop_front ? r_front :
                        i_cmd.pop_rear  ? w_rear_rd : w_walk_addr;

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_item_ext[DATA_WIDTH-1:0]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    // front pointer and count updates
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        if (i_cmd.push_front) begin
            n_front = w_front_dec;
            n_count = r_count + 1'b1;
        end else if (i_cmd.push_rear) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop_front) begin
            n_front = w_front_inc;
            n_count = r_count - 1'b1;
        end else if (i_cmd.pop_rear) begin
            n_count = r_count - 1'b1;
        end
    end

    // output register
    assign w_rd_ext   = EW'($signed(w_rd_data));
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.put_code) begin
            n_out_valid            = 1'b1;
            n_out_data.data_value  = '0;
            n_out_data.status      = i_cmd.code;
            n_out_data.last_of_run = 1'b1;
        end else if (i_cmd.put_word) begin
            n_out_valid            = 1'b1;
            n_out_data.data_value  = w_rd_ext[ITEM_WIDTH-1:0];
            n_out_data.status      = ST_OK;
            n_out_data.last_of_run = r_word_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_walk      <= '0;
            r_word_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_count     <= n_count;
            r_walk      <= n_walk;
            r_word_last <= n_word_last;
            r_out_valid <= n_out_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.out_free  = w_out_free;
    assign o_stat.word_last = r_word_last;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

    // checks
    `DQ_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "entry count above depth")
    `DQ_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_cmd.push_front || i_cmd.push_rear, r_count != CW'(DEPTH), "insert into full ring")
    `DQ_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_cmd.pop_front || i_cmd.pop_rear, r_count != '0, "removal from empty ring")
    `DQ_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, i_cmd.put_code || i_cmd.put_word, w_out_free, "output register overwritten")
    `DQ_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, i_cmd.push_front || i_cmd.push_rear, r_count == CW'($past(r_count) + 1'b1), "insert did not grow count")

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed words in a ring RAM
// Insert: result registered in the cycle after the transaction, one item per cycle while the output slot is free.
// Removal: result passes the registered RAM read, then the output register; no new item is taken until it is loaded.
// Listing of N entries: N results at one per cycle while the output slot is free, paced by the RAM read port.
// Reset clears front pointer, count and output valid; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dq_pkg::t_dq_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dq_pkg::t_dq_out_item o_out_data
);

    import dq_pkg::*;

    t_dq_cmd  w_cmd;
    t_dq_stat w_stat;

    // operation sequencing
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // storage and result path
    dq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item_value (i_in_data.item_value),
        .i_out_ready  (i_out_ready),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== tb/deque_checker.sv =====
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels of the deque. It keeps its own ring of words, front
// position and entry count, works out the results of every accepted operation
// and compares each returned transaction, field by field, with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  dq_pkg::t_dq_in_item  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  dq_pkg::t_dq_out_item i_out_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_ops_seen,
    output int                   o_results_seen,
    output int                   o_full_drops,
    output int                   o_empty_hits,
    output int                   o_longest_list
);
    import dq_pkg::*;

    localparam int MAX_PRINTED = 30;

    // predicted deque contents
    logic signed [ITEM_WIDTH-1:0] ring_words [DEPTH];
    int front_pos    = 0;
    int stored_count = 0;

    // results still owed by the block, oldest first
    t_dq_out_item expected_results [$];

    int fail_count   = 0;
    int ops_seen     = 0;
    int results_seen = 0;
    int full_drops   = 0;
    int empty_hits   = 0;
    int longest_list = 0;

    assign o_fail_count   = fail_count;
    assign o_ops_seen     = ops_seen;
    assign o_results_seen = results_seen;
    assign o_full_drops   = full_drops;
    assign o_empty_hits   = empty_hits;
    assign o_longest_list = longest_list;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("mismatch at %0t, result %0d: %s got %h expected %h",
                     $realtime, results_seen, what, got, want);
        end
    endtask

    // apply one operation to the predicted deque and queue its results
    task automatic predict_op(input t_dq_in_item op_item);
        t_dq_out_item res;
        int k;
        res             = '0;
        res.status      = ST_OK;
        res.last_of_run = 1'b1;
        ops_seen++;
        case (op_item.op)
            OP_INS_FRONT, OP_INS_REAR: begin
                if (stored_count == DEPTH) begin
                    res.status = ST_FULL;
                    full_drops++;
                end else if (op_item.op == OP_INS_FRONT) begin
                    front_pos = (front_pos + DEPTH - 1) % DEPTH;
                    ring_words[front_pos] = op_item.item_value;
                    stored_count++;
                end else begin
                    ring_words[(front_pos + stored_count) % DEPTH] = op_item.item_value;
                    stored_count++;
                end
                expected_results.push_back(res);
            end
            OP_REM_FRONT, OP_REM_REAR: begin
                if (stored_count == 0) begin
                    res.status = ST_EMPTY;
                    empty_hits++;
                end else if (op_item.op == OP_REM_FRONT) begin
                    res.data_value = ring_words[front_pos];
                    front_pos = (front_pos + 1) % DEPTH;
                    stored_count--;
                end else begin
                    res.data_value = ring_words[(front_pos + stored_count - 1) % DEPTH];
                    stored_count--;
                end
                expected_results.push_back(res);
            end
            OP_LIST: begin
                if (stored_count == 0) begin
                    res.status = ST_EMPTY;
                    empty_hits++;
                    expected_results.push_back(res);
                end else begin
                    for (k = 0; k < stored_count; k++) begin
                        res.data_value  = ring_words[(front_pos + k) % DEPTH];
                        res.last_of_run = (k == stored_count - 1);
                        expected_results.push_back(res);
                    end
                    if (stored_count > longest_list) longest_list = stored_count;
                end
            end
            default: begin
                // reserved codes leave the deque alone and return nothing
            end
        endcase
    endtask

    task automatic check_result(input t_dq_out_item got);
        t_dq_out_item want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, data_value",
                            got.data_value, '0);
        end else begin
            want = expected_results.pop_front();
            if (got.data_value !== want.data_value)
                report_mismatch("data_value", got.data_value, want.data_value);
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 32'(got.last_of_run),
                                32'(want.last_of_run));
        end
    endtask

    // results leave only after their transaction has been taken, so check first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_pos    = 0;
            stored_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) predict_op(i_in_data);
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the deque with a short directed sequence and then with fill and
// drain phases of random operations, stalling both channels at random.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_OPS   = 370;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 2_000_000;

    // codes the block does not define
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_ready;
    t_dq_in_item  in_data   = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    t_dq_out_item out_data;

    int fail_count;
    int pending;
    int ops_seen;
    int results_seen;
    int full_drops;
    int empty_hits;
    int longest_list;

    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  stall_on    = 1'b1;
    bit  in_idle_on  = 1'b1;
    int  level       = 0;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (ITEM_WIDTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    deque_checker #(
        .DEPTH (DEPTH)
    ) checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_ops_seen     (ops_seen),
        .o_results_seen (results_seen),
        .o_full_drops   (full_drops),
        .o_empty_hits   (empty_hits),
        .o_longest_list (longest_list)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'($urandom_range(0, 255));
            5:       return -32'($urandom_range(1, 256));
            default: return $urandom;
        endcase
    endfunction

    // result side back-pressure, with stretches of none
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if (stall_on && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
        end
        if ($urandom_range(0, 149) == 0) stall_on <= !stall_on;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // one transaction on the input channel; called and returns at a rising edge
    task automatic send_op(input logic [2:0] op, input logic [31:0] value);
        t_dq_in_item item;
        int gap;
        item.op         = op;
        item.item_value = value;
        gap = (in_idle_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // rough occupancy, only to steer the random phases
        if ((op == OP_INS_FRONT || op == OP_INS_REAR) && level < DEPTH) level++;
        if ((op == OP_REM_FRONT || op == OP_REM_REAR) && level > 0) level--;
        if ($urandom_range(0, 29) == 0) in_idle_on = !in_idle_on;
    endtask

    function automatic logic [2:0] pick_op(input bit filling);
        int r;
        logic [2:0] ins_op;
        logic [2:0] rem_op;
        r      = $urandom_range(0, 99);
        ins_op = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR;
        rem_op = $urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_REAR;
        if (filling) begin
            if (r < 60) return ins_op;
            if (r < 85) return rem_op;
            if (r < 97) return OP_LIST;
        end else begin
            if (r < 20) return ins_op;
            if (r < 80) return rem_op;
            if (r < 95) return OP_LIST;
        end
        return OP_RESERVED_FIRST + 3'($urandom_range(0, 2));
    endfunction

    initial begin
        int  counted;
        bit  filling;
        logic [2:0] op;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, both ends, wrap of the front pointer, reserved codes
        send_op(OP_LIST, rand_word());
        send_op(OP_REM_FRONT, rand_word());
        send_op(OP_REM_REAR, rand_word());
        send_op(OP_INS_FRONT, 32'h8000_0000);
        send_op(OP_INS_REAR, 32'h7fff_ffff);
        send_op(OP_INS_FRONT, 32'h0000_0000);
        send_op(OP_INS_REAR, 32'hffff_ffff);
        send_op(OP_INS_FRONT, 32'h5555_5555);
        send_op(OP_INS_REAR, 32'haaaa_aaaa);
        send_op(OP_LIST, rand_word());
        send_op(OP_REM_FRONT, rand_word());
        send_op(OP_REM_REAR, rand_word());
        send_op(OP_RESERVED_FIRST, rand_word());
        send_op(OP_RESERVED_FIRST + 3'd1, rand_word());
        send_op(OP_RESERVED_FIRST + 3'd2, rand_word());
        send_op(OP_LIST, rand_word());
        send_op(OP_REM_REAR, rand_word());
        send_op(OP_REM_FRONT, rand_word());
        send_op(OP_REM_FRONT, rand_word());
        send_op(OP_REM_REAR, rand_word());
        send_op(OP_REM_FRONT, rand_word());
        send_op(OP_LIST, rand_word());

        // alternating fill and drain phases so full and empty both come up often
        counted = 0;
        filling = 1'b1;
        while (counted < RANDOM_OPS) begin
            op = pick_op(filling);
            send_op(op, rand_word());
            if (op <= OP_LIST) counted++;
            if (filling && level == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
            else if (!filling && level == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
            else if ($urandom_range(0, 39) == 0) filling = !filling;
        end
        in_valid <= 1'b0;

        // drain, then give the block time to show any extra result
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("covered %0d operations and %0d results in %0d cycles",
                 ops_seen, results_seen, cycle_count);
        $display("full-queue drops %0d, empty-queue results %0d, longest listing %0d",
                 full_drops, empty_hits, longest_list);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
